// ----- rtl/core/tdss_pkg.sv -----
package tdss_pkg;

    localparam int DUTY_BITS_DEF       = 12;
    localparam int ACCEL_BITS_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 6;

    localparam int CORDIC_STEPS = 22;
    localparam int STEP_BITS    = 5;
    localparam int ANG_BITS     = 24;

    localparam logic [2:0] REG_FWD_ONE = 3'd0;
    localparam logic [2:0] REG_FWD_TWO = 3'd1;
    localparam logic [2:0] REG_REV     = 3'd2;
    localparam logic [2:0] REG_SWING_1 = 3'd3;
    localparam logic [2:0] REG_SWING_2 = 3'd4;
    localparam logic [2:0] REG_REPS    = 3'd5;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ONE  = 2'd1;
    localparam logic [1:0] MODE_TWO  = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_REV  = 2'd2;
    localparam logic [1:0] PH_RET  = 2'd3;

    // Arctangent of 2^-i in 2^-16 degree units.
    function automatic logic [ANG_BITS-1:0] atan_entry(input logic [STEP_BITS-1:0] i);
        logic [ANG_BITS-1:0] v;
        begin
            case (i)
                5'd0:  v = 24'd2949120;
                5'd1:  v = 24'd1740967;
                5'd2:  v = 24'd919879;
                5'd3:  v = 24'd466945;
                5'd4:  v = 24'd234379;
                5'd5:  v = 24'd117304;
                5'd6:  v = 24'd58666;
                5'd7:  v = 24'd29335;
                5'd8:  v = 24'd14668;
                5'd9:  v = 24'd7334;
                5'd10: v = 24'd3667;
                5'd11: v = 24'd1833;
                5'd12: v = 24'd917;
                5'd13: v = 24'd458;
                5'd14: v = 24'd229;
                5'd15: v = 24'd115;
                5'd16: v = 24'd57;
                5'd17: v = 24'd29;
                5'd18: v = 24'd14;
                5'd19: v = 24'd7;
                5'd20: v = 24'd4;
                5'd21: v = 24'd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/tdss_if.sv -----
interface tdss_in_if #(parameter int ACCEL_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic                         sample_new;
    logic signed [ACCEL_BITS-1:0] accel_x;
    logic signed [ACCEL_BITS-1:0] accel_y;
    logic signed [ACCEL_BITS-1:0] accel_z;
    logic                         button_up;
    logic                         button_down;
    modport source (output valid, sample_new, accel_x, accel_y, accel_z, button_up,
                    button_down, input ready);
    modport sink (input valid, sample_new, accel_x, accel_y, accel_z, button_up,
                  button_down, output ready);
endinterface

interface tdss_out_if #(parameter int DUTY_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic signed [13:0]     roll_angle;
    logic [DUTY_BITS-1:0]   duty_forward;
    logic [DUTY_BITS-1:0]   duty_reverse;
    logic [1:0]             active_routine;
    logic [1:0]             swing_phase;
    logic [7:0]             reps_done;
    modport source (output valid, roll_angle, duty_forward, duty_reverse, active_routine,
                    swing_phase, reps_done, input ready);
    modport sink (input valid, roll_angle, duty_forward, duty_reverse, active_routine,
                  swing_phase, reps_done, output ready);
endinterface

interface tdss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tdss_isqrt.sv -----
// Bit-pair restoring square root, one result bit per cycle.
module tdss_isqrt
    import tdss_pkg::*;
#(
    parameter int IN_BITS = 2 * ACCEL_BITS_DEF + 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [IN_BITS-1:0]     radicand,
    output logic                   done,
    output logic [IN_BITS/2:0]     root
);

    localparam int HALF  = (IN_BITS + 1) / 2;
    localparam int RB    = 2 * HALF;
    localparam int CNT_B = $clog2(HALF + 1);

    logic [RB-1:0]    rad_reg, rad_next;
    logic [RB+1:0]    rem_reg, rem_next;
    logic [HALF-1:0]  res_reg, res_next;
    logic [CNT_B-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [RB+1:0]    trial;
    logic [RB+1:0]    shifted;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[RB-1:0], rad_reg[RB-1 -: 2]};
        trial     = {{(RB+2-HALF-2){1'b0}}, res_reg, 2'b01};
        if (start)
        begin
            rad_next  = RB'(radicand);
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = CNT_B'(HALF);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (shifted >= trial)
            begin
                rem_next = shifted - trial;
                res_next = {res_reg[HALF-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                res_next = {res_reg[HALF-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_B'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_B'(1));
    assign root = (IN_BITS/2 + 1)'(res_next);

endmodule

// ----- rtl/core/tdss_cordic.sv -----
// Vectoring rotation, one micro-rotation per cycle through a shared shifter and adder pair.
module tdss_cordic
    import tdss_pkg::*;
#(
    parameter int XW = ACCEL_BITS_DEF + 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [XW-1:0]        x_init,
    input  logic [XW-1:0]        y_init,
    output logic                 done,
    output logic signed [ANG_BITS:0] angle
);

    localparam int W = XW + 3;

    logic signed [W-1:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_BITS:0]   ang_reg, ang_next;
    logic [STEP_BITS-1:0]       step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic signed [W-1:0]        dx, dy;

    function automatic logic signed [W-1:0] tsh(input logic signed [W-1:0] v,
                                                 input logic [STEP_BITS-1:0] s);
        logic [W-1:0] m;
        begin
            m = v[W-1] ? W'(-v) : W'(v);
            m = m >> s;
            return v[W-1] ? -$signed(m) : $signed(m);
        end
    endfunction

    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        ang_next  = ang_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        dx        = tsh(cy_reg, step_reg);
        dy        = tsh(cx_reg, step_reg);
        if (start)
        begin
            cx_next   = $signed({3'b000, x_init});
            cy_next   = $signed({3'b000, y_init});
            ang_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cy_reg > 0)
            begin
                cx_next  = cx_reg + dx;
                cy_next  = cy_reg - dy;
                ang_next = ang_reg + $signed({1'b0, atan_entry(step_reg)});
            end
            else
            begin
                cx_next  = cx_reg - dx;
                cy_next  = cy_reg + dy;
                ang_next = ang_reg - $signed({1'b0, atan_entry(step_reg)});
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_BITS'(CORDIC_STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        ang_reg <= ang_next;
    end

    assign done  = busy_reg && (step_reg == STEP_BITS'(CORDIC_STEPS - 1));
    assign angle = ang_next;

endmodule

// ----- rtl/core/tilt_driven_swing_sequencer.sv -----
// Flow: an item without a fresh sample or with zero y goes from ST_IDLE through ST_SEQ to
// ST_OUT; otherwise the square root (one bit per cycle) in ST_SQRT and 22 CORDIC
// micro-rotations in ST_ROT run first.
// Throughput: one transaction at a time; the next is accepted once the result is taken.
// Reset (rst_n, asynchronous, active low) loads the register defaults and clears
// the routine, phase, count and stored roll.
module tilt_driven_swing_sequencer
    import tdss_pkg::*;
#(
    parameter int DUTY_BITS       = DUTY_BITS_DEF,
    parameter int ACCEL_BITS      = ACCEL_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    tdss_in_if.sink    in_ch,
    tdss_out_if.source out_ch,
    tdss_cfg_if.sink   cfg
);

    // The squared sum is scaled by 2^16, so the root is the magnitude times 256.
    localparam int SQ_IN  = 2 * ACCEL_BITS + 17;
    localparam int ROOT_W = SQ_IN / 2 + 1;
    localparam int XW     = ACCEL_BITS + 9;
    localparam int SH     = 16 - ANGLE_FRAC_BITS;
    localparam int LIM    = 90 * (1 << ANGLE_FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQRT = 5'b00010,
        ST_ROT  = 5'b00100,
        ST_SEQ  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [DUTY_BITS-1:0] fwd1_reg, fwd2_reg, rev_reg;
    logic [12:0]          sw1_reg, sw2_reg;
    logic [7:0]           reps_reg;
    logic [1:0]           mode_reg, mode_next;
    logic [1:0]           phase_reg, phase_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic signed [13:0]   roll_reg, roll_next;
    logic                 up_reg, down_reg, yneg_reg;
    logic [ACCEL_BITS-1:0] ymag_reg;

    logic                 sq_start, sq_done, cr_start, cr_done;
    logic [ROOT_W-1:0]    root;
    logic signed [ANG_BITS:0] angle;
    logic [ANG_BITS:0]    ang_pos;
    logic [ANG_BITS:0]    mag_full;
    logic [13:0]          mag;
    logic signed [13:0]   swing;
    logic signed [ACCEL_BITS-1:0] ax, az;
    logic signed [2*ACCEL_BITS-1:0] xsq, zsq;
    logic [2*ACCEL_BITS:0] sumsq;
    logic [7:0]           cnt_inc;

    // The squares are formed at full width; each is non-negative, so the sum fits.
    assign ax    = in_ch.accel_x;
    assign az    = in_ch.accel_z;
    assign xsq   = ax * ax;
    assign zsq   = az * az;
    assign sumsq = {1'b0, xsq} + {1'b0, zsq};

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd1_reg <= DUTY_BITS'(850);
            fwd2_reg <= DUTY_BITS'(830);
            rev_reg  <= DUTY_BITS'(800);
            sw1_reg  <= 13'd640;
            sw2_reg  <= 13'd320;
            reps_reg <= 8'd5;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FWD_ONE: fwd1_reg <= DUTY_BITS'(cfg.data[11:0]);
                REG_FWD_TWO: fwd2_reg <= DUTY_BITS'(cfg.data[11:0]);
                REG_REV:     rev_reg  <= DUTY_BITS'(cfg.data[11:0]);
                REG_SWING_1: sw1_reg  <= cfg.data[12:0];
                REG_SWING_2: sw2_reg  <= cfg.data[12:0];
                REG_REPS:    reps_reg <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // The root unit loads the radicand straight from the accepted transaction.
    tdss_isqrt #(.IN_BITS(SQ_IN)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand({sumsq, 16'd0}),
        .done(sq_done), .root(root)
    );

    tdss_cordic #(.XW(XW)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cr_start),
        .x_init(XW'(root)), .y_init(XW'({ymag_reg, 8'd0})),
        .done(cr_done), .angle(angle)
    );

    // Round half away from zero (the angle is clamped to non-negative first), then limit.
    assign ang_pos  = angle[ANG_BITS] ? '0 : $unsigned(angle);
    assign mag_full = (ang_pos + ((ANG_BITS+1)'(1) << SH >> 1)) >> SH;
    assign mag      = (mag_full > (ANG_BITS+1)'(LIM)) ? 14'(LIM) : mag_full[13:0];

    assign swing   = (mode_reg == MODE_ONE) ? $signed({1'b0, sw1_reg})
                                            : $signed({1'b0, sw2_reg});
    assign cnt_inc = cnt_reg + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        roll_next  = roll_reg;
        sq_start   = 1'b0;
        cr_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.sample_new && (in_ch.accel_y == '0))
                    begin
                        roll_next  = '0;
                        state_next = ST_SEQ;
                    end
                    else if (in_ch.sample_new)
                        state_next = ST_SQRT;
                    else
                        state_next = ST_SEQ;
                end
            end
            ST_SQRT:
            begin
                if (sq_done)
                begin
                    cr_start   = 1'b1;
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (cr_done)
                begin
                    roll_next  = yneg_reg ? -$signed(mag) : $signed(mag);
                    state_next = ST_SEQ;
                end
            end
            ST_SEQ:
            begin
                state_next = ST_OUT;
                if (mode_reg == MODE_IDLE)
                begin
                    if (up_reg)
                    begin
                        mode_next = MODE_ONE; phase_next = PH_FWD; cnt_next = '0;
                    end
                    else if (down_reg)
                    begin
                        mode_next = MODE_TWO; phase_next = PH_FWD; cnt_next = '0;
                    end
                end
                else if (phase_reg == PH_FWD)
                begin
                    if (roll_reg > swing)
                        phase_next = PH_REV;
                end
                else if (phase_reg == PH_REV)
                begin
                    if (roll_reg < -swing)
                        phase_next = PH_RET;
                end
                else if (roll_reg > 0)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= reps_reg)
                    begin
                        mode_next = MODE_IDLE; phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_FWD;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        sq_start = (state_reg == ST_IDLE) && in_ch.valid && in_ch.sample_new
                   && (in_ch.accel_y != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_IDLE;
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            roll_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            roll_reg  <= roll_next;
        end
    end

    // The transaction's buttons and the sign and magnitude of y are captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            up_reg   <= in_ch.button_up;
            down_reg <= in_ch.button_down;
            yneg_reg <= in_ch.accel_y[ACCEL_BITS-1];
            ymag_reg <= in_ch.accel_y[ACCEL_BITS-1] ? ACCEL_BITS'(-in_ch.accel_y)
                                                    : ACCEL_BITS'(in_ch.accel_y);
        end
    end

    assign out_ch.valid          = (state_reg == ST_OUT);
    assign out_ch.roll_angle     = roll_reg;
    assign out_ch.duty_forward   = (phase_reg == PH_FWD || phase_reg == PH_RET)
                                   ? ((mode_reg == MODE_ONE) ? fwd1_reg : fwd2_reg) : '0;
    assign out_ch.duty_reverse   = (phase_reg == PH_REV) ? rev_reg : '0;
    assign out_ch.active_routine = mode_reg;
    assign out_ch.swing_phase    = phase_reg;
    assign out_ch.reps_done      = cnt_reg;

`ifndef SYNTHESIS
    a_phase_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) == (phase_reg == PH_IDLE))
        else $error("phase and routine disagree");
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        roll_reg <= 14'sd5760 && roll_reg >= -14'sd5760)
        else $error("roll out of range");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && !out_ch.ready |=> $stable(roll_reg) && $stable(phase_reg))
        else $error("result changed while stalled");
`endif

endmodule
